FILE: sv/cdfs_pkg.sv
// cdfs_pkg: shared constants, widths and helpers of the inverse-CDF categorical sampler.
// No dependencies; compiled first.
package cdfs_pkg;

    localparam int MAX_CATEGORIES = 1024;
    localparam int IDX_W          = $clog2(MAX_CATEGORIES);
    localparam int CNT_W          = $clog2(MAX_CATEGORIES + 1);
    localparam int SUM_W          = 58;
    localparam int MAX_DRAWS      = 64;
    localparam int DRAW_W         = 7;
    localparam int PHI_W          = 16;
    localparam int THETA_W        = 32;
    localparam int RNG_W          = 32;
    localparam int MUL_W          = 32;
    localparam int OUT_IDX_W      = 10;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 2;

    // register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_RNG_SEED = 2'd0;

    // input item codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // one xorshift32 step
    function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

FILE: sv/cdfs_if.sv
// cdfs_if: valid/ready channel interfaces for command beats and result beats.
// Depends on cdfs_pkg for field widths.
interface cdfs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic                          first_term;
    logic [cdfs_pkg::PHI_W-1:0]    phi_weight;
    logic [cdfs_pkg::THETA_W-1:0]  theta_weight;
    logic [cdfs_pkg::DRAW_W-1:0]   draw_count;

    modport source (output valid, mode, first_term, phi_weight, theta_weight, draw_count,
                    input ready);
    modport sink   (input valid, mode, first_term, phi_weight, theta_weight, draw_count,
                    output ready);
endinterface

interface cdfs_res_if;
    logic                            valid;
    logic                            ready;
    logic [cdfs_pkg::OUT_IDX_W-1:0]  sample_index;
    logic                            empty_row;
    logic                            last_sample;

    modport source (output valid, sample_index, empty_row, last_sample, input ready);
    modport sink   (input valid, sample_index, empty_row, last_sample, output ready);
endinterface

FILE: sv/cdfs_ram.sv
// cdfs_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module cdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/cdfs_mul.sv
// cdfs_mul: shared 32x32 unsigned multiplier with a registered product.
// Depends on cdfs_pkg for the operand width.
module cdfs_mul (
    input  logic                           clk,
    input  logic [cdfs_pkg::MUL_W-1:0]     a,
    input  logic [cdfs_pkg::MUL_W-1:0]     b,
    output logic [2*cdfs_pkg::MUL_W-1:0]   p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= {{cdfs_pkg::MUL_W{1'b0}}, a} * {{cdfs_pkg::MUL_W{1'b0}}, b};
    end

endmodule

FILE: sv/categorical_sampler_inverse_cdf.sv
// categorical_sampler_inverse_cdf: top level, sequencer, row state, generator and APB port.
// Depends on cdfs_pkg, cdfs_if, cdfs_ram and cdfs_mul.
//
// Usage
//   cmd beats: mode 0 loads one term; phi*theta is added to the running total and the
//   new total is appended to the row (first_term empties the row first; a term that
//   arrives with the row full is dropped). mode 1 draws draw_count samples (saturated
//   at 64), each drawn by xorshift32 and an inverse-CDF binary search of the row.
//   result beats: one per sample, last_sample marks the final beat of a draw; an empty
//   row returns index 0 with empty_row set.
//   A load adds its term in S_LOAD_ADD. A sample passes S_RNG, S_MUL_LO, S_MUL_HI,
//   S_THR, then S_PROBE and S_CMP per search probe (up to ceil(log2(terms loaded))
//   probes), then S_EMIT; the probe loop is bounded by the single registered read port
//   of the row memory, and the threshold by two passes through the one 32x32 multiplier.
//   cmd.ready is high only while no item is in flight. An empty row skips to S_EMIT.
//   The result register parts the two sides: the next cmd beat is taken while the last
//   result still waits; a stalled receiver holds further samples in the sequencer.
//   Reset: row empty, total zero, seed and generator state 1. No clearing pass; row
//   entries beyond the loaded count are never read.
//   APB: rng_seed at address 0, a write loads the generator at once (0 reads as 1).
module categorical_sampler_inverse_cdf (
    input  logic                          clk,
    input  logic                          rst_n,
    cdfs_cmd_if.sink                      cmd,
    cdfs_res_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdfs_pkg::APB_AW-1:0]   paddr,
    input  logic [cdfs_pkg::APB_DW-1:0]   pwdata,
    output logic [cdfs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_ADD,
        S_RNG,
        S_MUL_LO,
        S_MUL_HI,
        S_THR,
        S_PROBE,
        S_CMP,
        S_EMIT
    } state_t;

    localparam int IW = cdfs_pkg::IDX_W;
    localparam int CW = cdfs_pkg::CNT_W;
    localparam int SW = cdfs_pkg::SUM_W;
    localparam int MW = cdfs_pkg::MUL_W;
    localparam int RW = cdfs_pkg::RNG_W;
    localparam int DW = cdfs_pkg::DRAW_W;

    // control state
    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [DW-1:0]               left_reg, left_next;
    logic [RW-1:0]               seed_reg, seed_next;
    logic [RW-1:0]               rng_reg, rng_next;
    logic                        ovalid_reg, ovalid_next;

    // datapath
    logic [SW-1:0]               total_reg, total_next;
    logic [RW-1:0]               r_reg, r_next;
    logic [MW-1:0]               acc_reg, acc_next;
    logic [SW-1:0]               thr_reg, thr_next;
    logic [IW-1:0]               lo_reg, lo_next;
    logic [IW-1:0]               hi_reg, hi_next;
    logic [IW-1:0]               mid_reg, mid_next;
    logic [cdfs_pkg::OUT_IDX_W-1:0] oidx_reg, oidx_next;
    logic                        oempty_reg, oempty_next;
    logic                        olast_reg, olast_next;
    logic [IW-1:0]               res_idx_reg, res_idx_next;
    logic                        res_empty_reg, res_empty_next;

    // shared multiplier
    logic [MW-1:0]               mul_a, mul_b;
    logic [2*MW-1:0]             mul_p;

    // row memory
    logic                        ram_we, ram_re;
    logic [SW-1:0]               ram_wdata, ram_rdata;

    logic                        cmd_fire, cfg_wr, out_free;
    logic [SW-1:0]               sum_add;
    logic [IW:0]                 mid_sum;
    logic [RW-1:0]               rng_step;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr == cdfs_pkg::ADDR_RNG_SEED);
    assign out_free  = !ovalid_reg || result.ready;
    assign sum_add   = total_reg + mul_p[SW-1:0];
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign rng_step  = cdfs_pkg::xorshift32(rng_reg);

    assign cmd.ready           = (state_reg == S_IDLE);
    assign result.valid        = ovalid_reg;
    assign result.sample_index = oidx_reg;
    assign result.empty_row    = oempty_reg;
    assign result.last_sample  = olast_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == cdfs_pkg::ADDR_RNG_SEED) ? seed_reg : '0;

    // multiplier operand select: term product on accept, threshold halves when drawing
    always_comb
    begin
        unique case (state_reg)
            S_MUL_LO:
            begin
                mul_a = r_reg;
                mul_b = total_reg[MW-1:0];
            end
            S_MUL_HI:
            begin
                mul_a = r_reg;
                mul_b = {{(2*MW-SW){1'b0}}, total_reg[SW-1:MW]};
            end
            default:
            begin
                mul_a = cmd.theta_weight;
                mul_b = {{(MW-cdfs_pkg::PHI_W){1'b0}}, cmd.phi_weight};
            end
        endcase
    end

    cdfs_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    assign ram_we    = (state_reg == S_LOAD_ADD) && (count_reg < CW'(cdfs_pkg::MAX_CATEGORIES));
    assign ram_wdata = sum_add;
    assign ram_re    = (state_reg == S_PROBE);

    cdfs_ram #(
        .WIDTH (cdfs_pkg::SUM_W),
        .DEPTH (cdfs_pkg::MAX_CATEGORIES)
    ) u_row (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (mid_sum[IW:1]),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        seed_next      = seed_reg;
        rng_next       = rng_reg;
        ovalid_next    = ovalid_reg && !result.ready;
        total_next     = total_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        thr_next       = thr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        oidx_next      = oidx_reg;
        oempty_next    = oempty_reg;
        olast_next     = olast_reg;
        res_idx_next   = res_idx_reg;
        res_empty_next = res_empty_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.mode == cdfs_pkg::MODE_LOAD)
                    begin
                        if (cmd.first_term)
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        state_next = S_LOAD_ADD;
                    end
                    else if (cmd.draw_count != '0)
                    begin
                        left_next  = (cmd.draw_count > DW'(cdfs_pkg::MAX_DRAWS))
                                   ? DW'(cdfs_pkg::MAX_DRAWS) : cmd.draw_count;
                        state_next = S_RNG;
                    end
                end
            end
            S_LOAD_ADD:
            begin
                if (ram_we)
                begin
                    total_next = sum_add;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_RNG:
            begin
                rng_next = rng_step;
                r_next   = rng_step;
                if (count_reg == '0)
                begin
                    res_idx_next   = '0;
                    res_empty_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                acc_next   = mul_p[2*MW-1:MW];   // (r * total_lo) >> 32
                state_next = S_THR;
            end
            S_THR:
            begin
                thr_next   = mul_p[SW-1:0] + {{(SW-MW){1'b0}}, acc_reg};
                lo_next    = '0;
                hi_next    = IW'(count_reg - 1'b1);
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[IW:1];
                    state_next = S_CMP;
                end
                else
                begin
                    res_idx_next   = lo_reg;
                    res_empty_next = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (ram_rdata >= thr_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = S_PROBE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = cdfs_pkg::OUT_IDX_W'(res_idx_reg);
                    oempty_next = res_empty_reg;
                    olast_next  = (left_reg == DW'(1));
                    left_next   = left_reg - 1'b1;
                    state_next  = (left_reg == DW'(1)) ? S_IDLE : S_RNG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // user writes seed only when idle, unchecked; zero seed would lock the generator
        if (cfg_wr)
        begin
            seed_next = (pwdata == '0) ? RW'(1) : pwdata;
            rng_next  = seed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            left_reg   <= '0;
            seed_reg   <= RW'(1);
            rng_reg    <= RW'(1);
            ovalid_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            seed_reg   <= seed_next;
            rng_reg    <= rng_next;
            ovalid_reg <= ovalid_next;
            total_reg  <= total_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        thr_reg       <= thr_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        oidx_reg      <= oidx_next;
        oempty_reg    <= oempty_next;
        olast_reg     <= olast_next;
        res_idx_reg   <= res_idx_next;
        res_empty_reg <= res_empty_next;
    end

endmodule
